/* design/fm_pdd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the CORDIC arctangent table for the FM phase discriminator.
// No dependencies; used by every module of the block.
package fm_pdd_pkg;

   localparam int WINDOW_LENGTH_DEF  = 10;
   localparam int PHASE_BITS_DEF     = 16;
   localparam int CORDIC_STAGES_DEF  = 14;

   localparam int SAMPLE_W    = 8;
   localparam int AUDIO_W     = 16;
   localparam int DECIM_W     = 7;
   localparam int DECIM_CNT_W = 6;
   localparam logic [DECIM_W-1:0] DECIM_RESET = 7'd22;
   localparam logic [DECIM_W-1:0] DECIM_MAX   = 7'd64;

   localparam logic signed [SAMPLE_W:0] SAMPLE_OFFSET = 9'sd127;

   // CORDIC datapath: 24 fraction bits, 9-bit signed integer, gain headroom
   localparam int FRAC_BITS = 24;
   localparam int CORDIC_W  = 36;

   localparam int TABLE_LEN = 24;

   // atan(2^-k), full turn = 2^32
   localparam logic [31:0] ATAN_TURNS32 [TABLE_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic valid;
      logic start;   // item restarts phase reference, window and decimation
      logic origin;  // I and Q both zero: phase forced to zero
   } cell_ctrl_type;

   // arctangent step rounded to a phase word of pbits bits
   function automatic logic [31:0] atan_entry(input int k, input int pbits);
      logic [32:0] t;
      int          sh;
      sh = 32 - pbits;
      t  = {1'b0, ATAN_TURNS32[k]} + (33'd1 << (sh - 1));
      return 32'(t >> sh);
   endfunction

endpackage

/* design/fm_pdd_cordic_cell.sv */
`timescale 1ns / 1ps
// One vectoring CORDIC cell: a micro-rotation by atan(2^-STAGE) and a register.
// Depends on fm_pdd_pkg.
module fm_pdd_cordic_cell
   import fm_pdd_pkg::*;
#(
   parameter int STAGE      = 0,
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  cell_ctrl_type              ctrl_i,
   input  logic signed [CORDIC_W-1:0] x_i,
   input  logic signed [CORDIC_W-1:0] y_i,
   input  logic [PHASE_BITS-1:0]      z_i,
   output cell_ctrl_type              ctrl_o,
   output logic signed [CORDIC_W-1:0] x_o,
   output logic signed [CORDIC_W-1:0] y_o,
   output logic [PHASE_BITS-1:0]      z_o
);

   localparam logic [PHASE_BITS-1:0] ATAN_STEP = PHASE_BITS'(atan_entry(STAGE, PHASE_BITS));

   cell_ctrl_type              ctrl_ff;
   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic [PHASE_BITS-1:0]      z_ff, z_in;
   logic signed [CORDIC_W-1:0] x_sh, y_sh;

   assign x_sh = x_i >>> STAGE;
   assign y_sh = y_i >>> STAGE;

   always_comb begin
      if (!y_i[CORDIC_W-1]) begin
         x_in = x_i + y_sh;
         y_in = y_i - x_sh;
         z_in = z_i + ATAN_STEP;
      end else begin
         x_in = x_i - y_sh;
         y_in = y_i + x_sh;
         z_in = z_i - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign ctrl_o = ctrl_ff;
   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;

endmodule

/* design/fm_pdd_window.sv */
`timescale 1ns / 1ps
// Phase step, boxcar window over the last steps and decimation counter.
// Depends on fm_pdd_pkg.
module fm_pdd_window
   import fm_pdd_pkg::*;
#(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
   parameter int PHASE_BITS    = PHASE_BITS_DEF,
   localparam int SUM_W        = PHASE_BITS + $clog2(WINDOW_LENGTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  cell_ctrl_type           ctrl_i,
   input  logic [PHASE_BITS-1:0]   phase_i,
   input  logic [DECIM_W-1:0]      decim_factor,
   output logic                    emit_o,
   output logic signed [SUM_W-1:0] sum_o
);

   localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);

   logic [PHASE_BITS-1:0]        prev_ff, prev_in;
   logic                         have_prev_ff, have_prev_in;
   logic signed [PHASE_BITS-1:0] win_ff [WINDOW_LENGTH];
   logic signed [PHASE_BITS-1:0] win_in [WINDOW_LENGTH];
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic [DECIM_CNT_W-1:0]       decim_ff, decim_in;
   logic                         emit_ff, emit_in;

   logic [PHASE_BITS-1:0]        phase;
   logic signed [PHASE_BITS-1:0] step;
   logic [DECIM_W-1:0]           factor;
   logic [DECIM_CNT_W-1:0]       cnt;

   assign phase = ctrl_i.origin ? '0 : phase_i;
   // wrapped difference; a half turn reads as -pi
   assign step  = signed'(phase - prev_ff);

   always_comb begin
      if (decim_factor == '0) begin
         factor = DECIM_W'(1);
      end else if (decim_factor > DECIM_MAX) begin
         factor = DECIM_MAX;
      end else begin
         factor = decim_factor;
      end
      cnt = ({1'b0, decim_ff} >= factor) ? '0 : decim_ff;
   end

   always_comb begin
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      win_in       = win_ff;
      sum_in       = sum_ff;
      fill_in      = fill_ff;
      decim_in     = decim_ff;
      emit_in      = 1'b0;
      if (ctrl_i.valid) begin
         prev_in      = phase;
         have_prev_in = 1'b1;
         if (ctrl_i.start) begin
            for (int n = 0; n < WINDOW_LENGTH; n++) begin
               win_in[n] = '0;
            end
            sum_in   = '0;
            fill_in  = '0;
            decim_in = '0;
         end else if (have_prev_ff) begin
            win_in[0] = step;
            for (int n = 1; n < WINDOW_LENGTH; n++) begin
               win_in[n] = win_ff[n-1];
            end
            sum_in = sum_ff + SUM_W'(step) - SUM_W'(win_ff[WINDOW_LENGTH-1]);
            if (fill_ff < FILL_W'(WINDOW_LENGTH)) begin
               fill_in = fill_ff + 1'b1;
            end
            if (fill_in == FILL_W'(WINDOW_LENGTH)) begin
               emit_in  = (cnt == '0);
               decim_in = ({1'b0, cnt} + 1'b1 >= factor) ? '0 : cnt + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         for (int n = 0; n < WINDOW_LENGTH; n++) begin
            win_ff[n] <= '0;
         end
         sum_ff       <= '0;
         fill_ff      <= '0;
         decim_ff     <= '0;
         emit_ff      <= 1'b0;
      end else if (advance) begin
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         win_ff       <= win_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         decim_ff     <= decim_in;
         emit_ff      <= emit_in;
      end
   end

   assign emit_o = emit_ff;
   assign sum_o  = sum_ff;

endmodule

/* design/fm_pdd_mean.sv */
`timescale 1ns / 1ps
// Window mean: divide by the window length through a reciprocal multiply,
// rescale to pi = 32768 and saturate. Depends on fm_pdd_pkg.
module fm_pdd_mean
   import fm_pdd_pkg::*;
#(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
   parameter int PHASE_BITS    = PHASE_BITS_DEF,
   localparam int SUM_W        = PHASE_BITS + $clog2(WINDOW_LENGTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    valid_i,
   input  logic signed [SUM_W-1:0] sum_i,
   output logic                    valid_o,
   output logic [AUDIO_W-1:0]      audio_o
);

   localparam int SHL   = (PHASE_BITS < AUDIO_W) ? AUDIO_W - PHASE_BITS : 0;
   localparam int SHR   = (PHASE_BITS > AUDIO_W) ? PHASE_BITS - AUDIO_W : 0;
   localparam int NUM_W = SUM_W + SHL;
   localparam int RSH   = NUM_W + $clog2(WINDOW_LENGTH);
   localparam int MUL_W = RSH - $clog2(WINDOW_LENGTH) + 2;
   // ceil(2^RSH / WINDOW_LENGTH): exact floor division for every numerator
   localparam longint unsigned RECIP =
      ((64'd1 << RSH) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
   localparam logic [MUL_W-1:0] RECIP_K = MUL_W'(RECIP);

   logic [SUM_W-1:0]       mag;
   logic [NUM_W-1:0]       num;
   logic [NUM_W+MUL_W-1:0] prod_ff, prod_in;
   logic                   neg_ff;
   logic                   valid_ff;
   logic [NUM_W:0]         quot;

   assign mag     = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
   assign num     = (NUM_W'(mag) << SHL) >> SHR;
   assign prod_in = (NUM_W+MUL_W)'(num) * (NUM_W+MUL_W)'(RECIP_K);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         neg_ff  <= sum_i[SUM_W-1];
      end
   end

   // truncation toward zero, then clamp to the 16-bit range
   always_comb begin
      quot = (NUM_W+1)'(prod_ff >> RSH);
      if (neg_ff) begin
         if (quot > (NUM_W+1)'(32768)) begin
            audio_o = 16'h8000;
         end else begin
            audio_o = AUDIO_W'(-quot);
         end
      end else begin
         if (quot > (NUM_W+1)'(32767)) begin
            audio_o = 16'h7FFF;
         end else begin
            audio_o = AUDIO_W'(quot);
         end
      end
   end

   assign valid_o = valid_ff;

endmodule

/* design/fm_phase_discriminator_decimator_core.sv */
`timescale 1ns / 1ps
// FM phase discriminator with boxcar mean and decimation, top level.
// Depends on fm_pdd_pkg, fm_pdd_cordic_cell, fm_pdd_window and fm_pdd_mean.
//
// Takes one I/Q byte pair per cycle. The phase comes from a row of
// CORDIC_STAGES vectoring cells behind a half-plane fold register; the
// window/decimation cell, a reciprocal-multiply stage and the output register
// follow in that order. The whole row moves forward together and stands
// still only while a result waits in the output register and rsp_tready is
// low; otherwise one item is taken every cycle. The first item after reset or
// block_start only sets the phase reference; after that a result is made once
// WINDOW_LENGTH steps are in the window, and then on every decim_factor-th step
// (0 acts as 1, above 64 as 64). decim_factor is written on the csr channel,
// which is always ready.
module fm_phase_discriminator_decimator_core
   import fm_pdd_pkg::*;
#(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
   parameter int PHASE_BITS    = PHASE_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,   // i_sample [7:0], q_sample [15:8]
   input  logic               req_tuser,   // block_start
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [AUDIO_W-1:0] rsp_tdata,   // audio_sample [15:0]
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [DECIM_W-1:0] csr_data     // decim_factor
);

   localparam int SUM_W = PHASE_BITS + $clog2(WINDOW_LENGTH);

   logic               advance;
   logic [DECIM_W-1:0] decim_factor_ff;
   logic               rsp_valid_ff;
   logic [AUDIO_W-1:0] rsp_data_ff;

   // fold stage
   logic signed [SAMPLE_W:0]   i_c, q_c;
   logic signed [CORDIC_W-1:0] i_w, q_w;
   cell_ctrl_type              front_ctrl_ff, front_ctrl_in;
   logic signed [CORDIC_W-1:0] front_x_ff, front_x_in;
   logic signed [CORDIC_W-1:0] front_y_ff, front_y_in;
   logic [PHASE_BITS-1:0]      front_z_ff, front_z_in;

   cell_ctrl_type              chain_ctrl [CORDIC_STAGES+1];
   logic signed [CORDIC_W-1:0] chain_x    [CORDIC_STAGES+1];
   logic signed [CORDIC_W-1:0] chain_y    [CORDIC_STAGES+1];
   logic [PHASE_BITS-1:0]      chain_z    [CORDIC_STAGES+1];

   logic                    win_emit;
   logic signed [SUM_W-1:0] win_sum;
   logic                    mean_valid;
   logic [AUDIO_W-1:0]      mean_audio;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         decim_factor_ff <= DECIM_RESET;
      end else if (csr_valid) begin
         decim_factor_ff <= csr_data;
      end
   end

   assign i_c = signed'({1'b0, req_tdata[7:0]}) - SAMPLE_OFFSET;
   assign q_c = signed'({1'b0, req_tdata[15:8]}) - SAMPLE_OFFSET;
   assign i_w = CORDIC_W'(i_c) <<< FRAC_BITS;
   assign q_w = CORDIC_W'(q_c) <<< FRAC_BITS;

   // left half plane: turn by a half turn first
   always_comb begin
      front_ctrl_in.valid  = req_tvalid;
      front_ctrl_in.start  = req_tuser;
      front_ctrl_in.origin = (i_c == '0) && (q_c == '0);
      if (i_c[SAMPLE_W]) begin
         front_x_in = -i_w;
         front_y_in = -q_w;
         front_z_in = PHASE_BITS'(1) << (PHASE_BITS - 1);
      end else begin
         front_x_in = i_w;
         front_y_in = q_w;
         front_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ctrl_ff <= '0;
      end else if (advance) begin
         front_ctrl_ff <= front_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_x_ff <= front_x_in;
         front_y_ff <= front_y_in;
         front_z_ff <= front_z_in;
      end
   end

   assign chain_ctrl[0] = front_ctrl_ff;
   assign chain_x[0]    = front_x_ff;
   assign chain_y[0]    = front_y_ff;
   assign chain_z[0]    = front_z_ff;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      fm_pdd_cordic_cell #(
         .STAGE      (k),
         .PHASE_BITS (PHASE_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctrl_i  (chain_ctrl[k]),
         .x_i     (chain_x[k]),
         .y_i     (chain_y[k]),
         .z_i     (chain_z[k]),
         .ctrl_o  (chain_ctrl[k+1]),
         .x_o     (chain_x[k+1]),
         .y_o     (chain_y[k+1]),
         .z_o     (chain_z[k+1])
      );
   end

   fm_pdd_window #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .PHASE_BITS    (PHASE_BITS)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .ctrl_i       (chain_ctrl[CORDIC_STAGES]),
      .phase_i      (chain_z[CORDIC_STAGES]),
      .decim_factor (decim_factor_ff),
      .emit_o       (win_emit),
      .sum_o        (win_sum)
   );

   fm_pdd_mean #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .PHASE_BITS    (PHASE_BITS)
   ) u_mean (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .valid_i (win_emit),
      .sum_i   (win_sum),
      .valid_o (mean_valid),
      .audio_o (mean_audio)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mean_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= mean_audio;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fm_phase_discriminator_decimator_core.
// Needs fm_pdd_pkg and the core; predicts each audio item from the I/Q items that
// the core accepts and checks the results in order, under random pacing on both sides.
module tb_top;
   import fm_pdd_pkg::*;

   localparam int  CLK_PERIOD   = 20;
   localparam int  RESET_CYCLES = 6;
   localparam int  MAX_GAP      = 13;
   localparam int  DRAIN_CYCLES = CORDIC_STAGES_DEF + 4 + 16;
   localparam int  LONG_HOLD    = 300;
   localparam int  CYCLE_LIMIT  = 200000;
   localparam int  MAX_REPORTS  = 10;
   localparam int  IQ_CENTER    = 127;
   localparam logic [15:0] HALF_TURN = 16'h8000;
   localparam logic [DECIM_W-1:0] DECIM_MIN = 7'd1;

   typedef struct packed {
      logic       start;
      logic [7:0] q;
      logic [7:0] i;
   } iq_item_type;

   // {start, q, i}: quadrant corners, origin, one-LSB offsets, half-turn steps,
   // a restart in the middle of a window
   localparam logic [16:0] DIRECTED [24] = '{
      {1'b1, 8'd127, 8'd127}, {1'b0, 8'd127, 8'd255}, {1'b0, 8'd255, 8'd127},
      {1'b0, 8'd127, 8'd0},   {1'b0, 8'd0,   8'd127}, {1'b0, 8'd255, 8'd255},
      {1'b0, 8'd0,   8'd0},   {1'b0, 8'd0,   8'd255}, {1'b0, 8'd255, 8'd0},
      {1'b0, 8'd127, 8'd128}, {1'b0, 8'd127, 8'd126}, {1'b0, 8'd127, 8'd127},
      {1'b0, 8'd127, 8'd255}, {1'b0, 8'd127, 8'd0},   {1'b0, 8'd127, 8'd255},
      {1'b0, 8'd127, 8'd0},   {1'b0, 8'd128, 8'd127}, {1'b0, 8'd126, 8'd127},
      {1'b1, 8'd127, 8'd127}, {1'b0, 8'd127, 8'd255}, {1'b0, 8'd255, 8'd127},
      {1'b0, 8'd127, 8'd0},   {1'b0, 8'd0,   8'd127}, {1'b0, 8'd127, 8'd255}
   };

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [15:0]        req_tdata  = '0;   // i_sample [7:0], q_sample [15:8]
   logic               req_tuser  = 1'b0; // block_start
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [AUDIO_W-1:0] rsp_tdata;         // audio_sample [15:0]
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [DECIM_W-1:0] csr_data   = DECIM_RESET; // decim_factor

   fm_phase_discriminator_decimator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // discriminator state mirrored by the testbench
   logic [DECIM_W-1:0] decim_factor_reg = DECIM_RESET;
   logic [15:0]        ref_angle = '0;
   bit                 have_ref  = 1'b0;
   int                 win_steps [WINDOW_LENGTH_DEF];
   int                 win_sum   = 0;
   int                 win_fill  = 0;
   int                 wr_slot   = 0;
   int                 decim_pos = 0;

   logic [AUDIO_W-1:0] expected_audio [$];
   iq_item_type        pending_iq [$];
   iq_item_type        req_item;

   int  items_queued  = 0;
   int  items_taken   = 0;
   int  audio_checked = 0;
   int  errors        = 0;
   int  stall_cycles  = 0;
   int  settings_used = 1;
   int  cycle_count   = 0;

   bit  req_fire = 1'b0, rsp_fire = 1'b0, csr_fire = 1'b0;
   bit  req_holding = 1'b0;
   bit  req_idle = 1'b0, rsp_idle = 1'b0;
   int  req_gap = 0, rsp_wait = 0;
   int  hold_trigger = 0, hold_seen = 0, hold_left = 0;
   logic rsp_hold = 1'b0;

   // vectoring CORDIC, full turn = 2^16
   function automatic logic [15:0] iq_angle(input logic [7:0] ib, input logic [7:0] qb);
      int          iv, qv, k;
      longint      x, y, xs, ys;
      logic [15:0] z, step;
      iv = int'(ib) - IQ_CENTER;
      qv = int'(qb) - IQ_CENTER;
      if (iv == 0 && qv == 0) return '0;
      x = longint'(iv) * 16777216;
      y = longint'(qv) * 16777216;
      z = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = HALF_TURN;
      end
      for (k = 0; k < CORDIC_STAGES_DEF; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         step = 16'((ATAN_TURNS32[k] + 32'h8000) >> 16);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + step;
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - step;
         end
      end
      return z;
   endfunction

   function automatic void clear_window();
      int n;
      for (n = 0; n < WINDOW_LENGTH_DEF; n++) win_steps[n] = 0;
      win_sum   = 0;
      win_fill  = 0;
      wr_slot   = 0;
      decim_pos = 0;
   endfunction

   function automatic void advance_discriminator(input iq_item_type it);
      logic [15:0] ang, du;
      int          d, f, mean;
      bit          emit;
      ang = iq_angle(it.i, it.q);
      if (it.start) begin
         clear_window();
         have_ref = 1'b0;
      end
      if (!have_ref) begin
         ref_angle = ang;
         have_ref  = 1'b1;
         return;
      end
      du = ang - ref_angle;    // wraps mod a full turn; a half turn reads as -pi
      d  = int'($signed(du));
      ref_angle = ang;
      if (wr_slot >= WINDOW_LENGTH_DEF) wr_slot = 0;
      win_sum += d - win_steps[wr_slot];
      win_steps[wr_slot] = d;
      wr_slot = (wr_slot + 1 >= WINDOW_LENGTH_DEF) ? 0 : wr_slot + 1;
      if (win_fill < WINDOW_LENGTH_DEF) win_fill++;
      if (win_fill < WINDOW_LENGTH_DEF) return;
      f = int'(decim_factor_reg);
      if (f < 1) f = 1;
      if (f > int'(DECIM_MAX)) f = int'(DECIM_MAX);
      if (decim_pos >= f) decim_pos = 0;   // factor lowered mid-stream
      emit = (decim_pos == 0);
      decim_pos = (decim_pos + 1 >= f) ? 0 : decim_pos + 1;
      if (!emit) return;
      mean = win_sum / WINDOW_LENGTH_DEF;  // truncates toward zero
      if (mean > 32767) mean = 32767;
      if (mean < -32768) mean = -32768;
      expected_audio = {expected_audio, AUDIO_W'(mean)};
   endfunction

   // ---------------- input side ----------------
   always @(posedge clock) begin : req_accept
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            advance_discriminator(req_item);
            items_taken++;
            req_fire = 1'b1;
         end else if (req_tvalid) begin
            stall_cycles++;
         end
      end
   end

   always @(negedge clock) begin : req_driver
      if (req_fire) begin
         req_fire    = 1'b0;
         req_holding = 1'b0;
      end
      if (!reset && !req_holding) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_iq.size() > 0) begin
            req_item    = pending_iq.pop_front();
            req_holding = 1'b1;
            req_tdata  <= {req_item.q, req_item.i};
            req_tuser  <= req_item.start;
            req_gap     = req_idle ? $urandom_range(0, MAX_GAP) : 0;
         end
      end
      req_tvalid <= req_holding;
   end

   // ---------------- result side ----------------
   always @(posedge clock) begin : rsp_check
      logic [AUDIO_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_fire = 1'b1;
         if (expected_audio.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("ERROR @%0t: audio item %0d arrived with nothing expected",
                        $realtime, rsp_tdata);
         end else begin
            want = expected_audio.pop_front();
            audio_checked++;
            if (rsp_tdata !== want) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("ERROR @%0t: audio_sample expected %0d (0x%h) got %0d (0x%h)",
                           $realtime, $signed(want), want, $signed(rsp_tdata), rsp_tdata);
            end
         end
      end
   end

   always @(negedge clock) begin : rsp_driver
      if (rsp_fire) begin
         rsp_fire = 1'b0;
         rsp_wait = rsp_idle ? $urandom_range(0, MAX_GAP) : 0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
      end
      rsp_tready <= !reset && (rsp_wait == 0) && !rsp_hold;
   end

   // long back-pressure window so the pipeline fills and stalls its input
   always @(posedge clock) begin : rsp_hold_off
      if (hold_seen != hold_trigger) begin
         hold_seen = hold_trigger;
         hold_left = LONG_HOLD;
      end else if (hold_left > 0) begin
         hold_left--;
      end
      rsp_hold <= (hold_left > 0);
   end

   // ---------------- register channel ----------------
   always @(posedge clock) begin : csr_accept
      if (!reset && csr_valid && csr_ready) begin
         decim_factor_reg = csr_data;
         csr_fire = 1'b1;
      end
   end

   task automatic write_decim(input logic [DECIM_W-1:0] value);
      @(negedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_fire);
      csr_fire = 1'b0;
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic set_pacing(input bit sender_idles, input bit receiver_idles);
      @(posedge clock);
      req_idle = sender_idles;
      rsp_idle = receiver_idles;
   endtask

   // every item accepted and answered, then room for items still in flight
   task automatic wait_drained();
      while (items_taken != items_queued || expected_audio.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic queue_directed();
      int n;
      for (n = 0; n < 24; n++) pending_iq = {pending_iq, iq_item_type'(DIRECTED[n])};
      items_queued += 24;
   endtask

   // runs of tones with wandering frequency, mixed with raw noise, corner values
   // and constant input; most runs open with a block start
   task automatic queue_stream(input int count);
      int          left, run_len, kind, n, iv, qv, ci, cq;
      real         amp, theta, w, dev, m;
      iq_item_type it;
      left = count;
      while (left > 0) begin
         run_len = $urandom_range(12, 90);
         if (run_len > left) run_len = left;
         kind  = $urandom_range(0, 9);
         amp   = $urandom_range(8, 130);
         theta = $urandom_range(0, 6283) / 1000.0;
         w     = ($urandom_range(0, 6000) - 3000.0) / 1000.0;
         dev   = $urandom_range(0, 1500) / 1000.0;
         m     = $urandom_range(1, 300) / 1000.0;
         ci    = $urandom_range(0, 255);
         cq    = $urandom_range(0, 255);
         for (n = 0; n < run_len; n++) begin
            case (kind)
               6, 7: begin
                  iv = $urandom_range(0, 255);
                  qv = $urandom_range(0, 255);
               end
               8: begin
                  case ($urandom_range(0, 4))
                     0: iv = 0;
                     1: iv = 255;
                     2: iv = 126;
                     3: iv = 128;
                     default: iv = IQ_CENTER;
                  endcase
                  qv = ($urandom_range(0, 1) != 0) ? 255 - iv : iv;
               end
               9: begin
                  iv = ci;
                  qv = cq;
               end
               default: begin
                  theta = theta + w + dev * $sin(m * n);
                  iv = int'(127.0 + amp * $cos(theta));
                  qv = int'(127.0 + amp * $sin(theta));
               end
            endcase
            if (iv < 0) iv = 0;
            if (iv > 255) iv = 255;
            if (qv < 0) qv = 0;
            if (qv > 255) qv = 255;
            it.i = 8'(iv);
            it.q = 8'(qv);
            it.start = (n == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 63) == 0);
            pending_iq = {pending_iq, it};
         end
         items_queued += run_len;
         left -= run_len;
      end
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // factor left at its reset value
      set_pacing(1'b1, 1'b1);
      queue_stream(80);
      wait_drained();

      write_decim(DECIM_MIN);
      set_pacing(1'b0, 1'b0);
      queue_directed();
      wait_drained();

      // receiver holds off while the sender keeps offering
      @(negedge clock);
      hold_trigger++;
      queue_stream(100);
      wait_drained();

      write_decim(DECIM_MAX);
      set_pacing(1'b1, 1'b0);
      queue_stream(200);
      wait_drained();

      write_decim('0);           // acts as 1
      set_pacing(1'b0, 1'b1);
      queue_stream(60);
      wait_drained();

      write_decim('1);           // clamps to 64
      set_pacing(1'b1, 1'b1);
      queue_stream(60);
      wait_drained();

      write_decim(7'd3);
      set_pacing(1'b1, 1'b1);
      queue_stream(100);
      wait_drained();

      write_decim(DECIM_MAX + 7'd1);
      set_pacing(1'b1, 1'b0);
      queue_stream(40);
      wait_drained();

      write_decim(DECIM_W'($urandom_range(2, 10)));
      set_pacing(1'b1, 1'b1);
      queue_stream(100);
      wait_drained();

      $display("Run covered %0d I/Q items and %0d audio items over %0d decimation settings,",
               items_taken, audio_checked, settings_used);
      $display("with %0d cycles of input back-pressure and %0d failures.",
               stall_cycles, errors);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d items still expected",
               cycle_count, expected_audio.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* filelist.f */
design/fm_pdd_pkg.sv
design/fm_pdd_cordic_cell.sv
design/fm_pdd_window.sv
design/fm_pdd_mean.sv
design/fm_phase_discriminator_decimator_core.sv
test/tb_top.sv
